// ===== rtl/rc4_pkg.sv =====
// Shared constants, operation codes and memory request type of the RC4 engine.
package rc4_pkg;

   localparam int KEY_MAX_BYTES_DEF = 256;
   localparam int PERM_DEPTH        = 256;
   localparam int PERM_AW           = 8;
   localparam int LEN_W             = 9;

   localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

   localparam logic [1:0] OP_KEY    = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic               we;
      logic [PERM_AW-1:0] addr;
      logic [7:0]         wdata;
   } perm_req_type;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 engine top level: register port, sequencer and the permutation and key memories.
// A key byte load or an unused op gives its result in the cycle after acceptance; busy stays low.
// A data byte holds busy through states D0 to D5, and a new byte is taken only once its result is out.
// The key schedule fills the permutation in INIT, then runs K0 to K4 per entry; result the cycle after.
// The sequencing is set by the single port of the permutation memory, and no result can be held off.
// Synchronous reset clears the indices and sequencer and sets the key length to 16.
module rc4_stream_cipher
   import rc4_pkg::*;
#(
   parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
   localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_key_slot,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_is_data,
   output logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [LEN_W-1:0] key_length;
   perm_req_type     perm_req;
   logic [7:0]       perm_rdata;
   logic             key_we;
   logic [KW-1:0]    key_addr;
   logic [7:0]       key_wdata;
   logic [7:0]       key_rdata;

   rc4_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .key_length (key_length)
   );

   rc4_ram #(
      .WIDTH (8),
      .DEPTH (PERM_DEPTH)
   ) u_perm_ram (
      .clock (clock),
      .we    (perm_req.we),
      .addr  (perm_req.addr),
      .wdata (perm_req.wdata),
      .rdata (perm_rdata)
   );

   rc4_ram #(
      .WIDTH (8),
      .DEPTH (KEY_MAX_BYTES)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .addr  (key_addr),
      .wdata (key_wdata),
      .rdata (key_rdata)
   );

   rc4_engine #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_op       (req_op),
      .req_key_slot (req_key_slot),
      .req_byte_in  (req_byte_in),
      .req_last_in  (req_last_in),
      .key_length   (key_length),
      .busy         (busy),
      .perm_req     (perm_req),
      .perm_rdata   (perm_rdata),
      .key_we       (key_we),
      .key_addr     (key_addr),
      .key_wdata    (key_wdata),
      .key_rdata    (key_rdata),
      .rsp_valid    (rsp_valid),
      .rsp_byte_out (rsp_byte_out),
      .rsp_is_data  (rsp_is_data),
      .rsp_last_out (rsp_last_out)
   );

   // Results are only ever presented once the sequencer has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result presented while the engine is busy");

   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_KEY || req_op == OP_UNUSED)) |=> (rsp_valid && !busy))
      else $error("key load item did not complete in one cycle");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_DATA || req_op == OP_SCHED)) |=> (busy && !rsp_valid))
      else $error("long item did not raise busy");

   a_perm_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !perm_req.we)
      else $error("permutation written while idle");

endmodule

// ===== rtl/rc4_ram.sv =====
// Generic single-port RAM with registered read data.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

// ===== rtl/rc4_csr.sv =====
// APB-style register block holding the key length.
module rc4_csr
   import rc4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [LEN_W-1:0] key_length
);

   logic [LEN_W-1:0] key_length_ff;
   logic [LEN_W-1:0] key_length_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && !paddr[2];

   always_comb begin
      key_length_in = key_length_ff;
      if (wr_hit) begin
         key_length_in = pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
      end else begin
         key_length_ff <= key_length_in;
      end
   end

   assign prdata     = paddr[2] ? 32'd0 : {{(32 - LEN_W){1'b0}}, key_length_ff};
   assign key_length = key_length_ff;

endmodule

// ===== rtl/rc4_engine.sv =====
// Sequencer and shared byte adder that run the key schedule and the keystream steps.
module rc4_engine
   import rc4_pkg::*;
#(
   parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF,
   localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_key_slot,
   input  logic [7:0]       req_byte_in,
   input  logic             req_last_in,
   input  logic [LEN_W-1:0] key_length,
   output logic             busy,
   output perm_req_type     perm_req,
   input  logic [7:0]       perm_rdata,
   output logic             key_we,
   output logic [KW-1:0]    key_addr,
   output logic [7:0]       key_wdata,
   input  logic [7:0]       key_rdata,
   output logic             rsp_valid,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_is_data,
   output logic             rsp_last_out
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'h0001,
      ST_INIT = 13'h0002,
      ST_K0   = 13'h0004,
      ST_K1   = 13'h0008,
      ST_K2   = 13'h0010,
      ST_K3   = 13'h0020,
      ST_K4   = 13'h0040,
      ST_D0   = 13'h0080,
      ST_D1   = 13'h0100,
      ST_D2   = 13'h0200,
      ST_D3   = 13'h0400,
      ST_D4   = 13'h0800,
      ST_D5   = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]    i_ff, i_in, j_ff, j_in, acc_ff, acc_in;
   logic [7:0]    n_ff, n_in, si_ff, si_in, sj_ff, sj_in;
   logic [7:0]    dbyte_ff, dbyte_in;
   logic          dlast_ff, dlast_in;
   logic [KW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]       add_a, add_b, add_sum;
   logic [LEN_W-1:0] len_eff;
   logic             k_last;
   logic             slot_ok;

   // Zero length behaves as one; lengths beyond the store saturate.
   always_comb begin
      if (key_length == '0) begin
         len_eff = LEN_W'(1);
      end else if ({1'b0, key_length} > (LEN_W + 1)'(KEY_MAX_BYTES)) begin
         len_eff = LEN_W'(KEY_MAX_BYTES);
      end else begin
         len_eff = key_length;
      end
   end

   assign k_last  = ((LEN_W + 1)'(k_ff) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(len_eff);
   assign slot_ok = {1'b0, req_key_slot} < 9'(KEY_MAX_BYTES);

   // The one byte adder shared by the K1, K2, D0, D1 and D4 steps of the two sequences.
   always_comb begin
      add_a = acc_ff;
      add_b = si_ff;
      unique case (state_ff)
         ST_K1: begin
            add_a = acc_ff;
            add_b = key_rdata;
         end
         ST_D0: begin
            add_a = i_ff;
            add_b = 8'd1;
         end
         ST_D1: begin
            add_a = j_ff;
            add_b = perm_rdata;
         end
         ST_D4: begin
            add_a = si_ff;
            add_b = sj_ff;
         end
         default: begin
            add_a = acc_ff;
            add_b = si_ff;
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      dbyte_in     = dbyte_ff;
      dlast_in     = dlast_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = 8'd0;
      rsp_data_in  = 1'b0;
      rsp_last_in  = 1'b0;
      perm_req     = '{we: 1'b0, addr: n_ff, wdata: n_ff};
      key_we       = 1'b0;
      key_addr     = k_ff;
      key_wdata    = req_byte_in;

      unique case (state_ff)
         ST_IDLE: begin
            key_addr = req_key_slot[KW-1:0];
            if (start) begin
               unique case (req_op)
                  OP_KEY: begin
                     key_we       = slot_ok;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SCHED: begin
                     state_in = ST_INIT;
                     n_in     = 8'd0;
                     k_in     = '0;
                     acc_in   = 8'd0;
                  end
                  OP_DATA: begin
                     state_in = ST_D0;
                     dbyte_in = req_byte_in;
                     dlast_in = req_last_in;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INIT: begin
            perm_req = '{we: 1'b1, addr: n_ff, wdata: n_ff};
            n_in     = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               state_in = ST_K0;
            end
         end
         ST_K0: begin
            state_in = ST_K1;
         end
         ST_K1: begin
            si_in    = perm_rdata;
            acc_in   = add_sum;
            state_in = ST_K2;
         end
         ST_K2: begin
            acc_in        = add_sum;
            perm_req.addr = add_sum;
            state_in      = ST_K3;
         end
         ST_K3: begin
            perm_req = '{we: 1'b1, addr: n_ff, wdata: perm_rdata};
            state_in = ST_K4;
         end
         ST_K4: begin
            perm_req = '{we: 1'b1, addr: acc_ff, wdata: si_ff};
            n_in     = n_ff + 8'd1;
            k_in     = k_last ? '0 : KW'(k_ff + 1'b1);
            if (n_ff == 8'hFF) begin
               i_in         = 8'd0;
               j_in         = 8'd0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         ST_D0: begin
            i_in          = add_sum;
            perm_req.addr = add_sum;
            state_in      = ST_D1;
         end
         ST_D1: begin
            si_in         = perm_rdata;
            j_in          = add_sum;
            perm_req.addr = add_sum;
            state_in      = ST_D2;
         end
         ST_D2: begin
            perm_req = '{we: 1'b1, addr: i_ff, wdata: perm_rdata};
            sj_in    = perm_rdata;
            state_in = ST_D3;
         end
         ST_D3: begin
            perm_req = '{we: 1'b1, addr: j_ff, wdata: si_ff};
            state_in = ST_D4;
         end
         ST_D4: begin
            perm_req.addr = add_sum;
            state_in      = ST_D5;
         end
         ST_D5: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = dbyte_ff ^ perm_rdata;
            rsp_data_in  = 1'b1;
            rsp_last_in  = dlast_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      dbyte_ff    <= dbyte_in;
      dlast_ff    <= dlast_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_is_data  = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule
